### hw/rtl/rmq_pkg.sv
package rmq_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int ELEM_W        = 16;
   localparam int MAG_W         = 17;
   localparam int QUOT_W        = 16;

   typedef enum logic [1:0] {
      CASE_W = 2'd0,
      CASE_X = 2'd1,
      CASE_Y = 2'd2,
      CASE_Z = 2'd3
   } case_type;

   // Control word that travels with each request down the chain.
   typedef struct packed {
      logic       valid;
      case_type   sel;
      logic       bad;
      logic [2:0] neg;
   } ctl_type;

   // Width of the radicand once it is known to be positive.
   function automatic int rad_w(input int f);
      return ((f > 18) ? f : 18) + 1;
   endfunction

   // Number of square root bits, one per cell.
   function automatic int root_w(input int f);
      return (rad_w(f) + f + 1) / 2;
   endfunction

   // Width of the long division remainder.
   function automatic int div_w(input int f);
      return f + 19 + root_w(f) + 1;
   endfunction

endpackage

### hw/rtl/rmq_front.sv
module rmq_front
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [8:0][ELEM_W-1:0]              elem,
   output ctl_type                             ctl_ff,
   output logic [2*root_w(FRAC_BITS)-1:0]      v_ff,
   output logic [2:0][MAG_W-1:0]               mag_ff
);
   localparam int RW  = rad_w(FRAC_BITS);
   localparam int EW  = RW + 1;
   localparam int VW  = 2 * root_w(FRAC_BITS);
   localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

   logic signed [EW-1:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
   logic signed [EW-1:0] tr, rad;
   logic signed [EW-1:0] num [3];
   ctl_type ctl_in;
   logic [VW-1:0] v_in;
   logic [2:0][MAG_W-1:0] mag_in;

   always_comb begin
      a11 = EW'(signed'(elem[0]));
      a12 = EW'(signed'(elem[1]));
      a13 = EW'(signed'(elem[2]));
      a21 = EW'(signed'(elem[3]));
      a22 = EW'(signed'(elem[4]));
      a23 = EW'(signed'(elem[5]));
      a31 = EW'(signed'(elem[6]));
      a32 = EW'(signed'(elem[7]));
      a33 = EW'(signed'(elem[8]));
      tr  = a11 + a22 + a33;
      ctl_in.valid = in_valid;
      if (tr > 0) begin
         ctl_in.sel = CASE_W;
         rad = ONE + tr;
         num[0] = a32 - a23; num[1] = a13 - a31; num[2] = a21 - a12;
      end else if (a11 > a22 && a11 > a33) begin
         ctl_in.sel = CASE_X;
         rad = ONE + a11 - a22 - a33;
         num[0] = a32 - a23; num[1] = a12 + a21; num[2] = a13 + a31;
      end else if (a22 > a33) begin
         ctl_in.sel = CASE_Y;
         rad = ONE + a22 - a11 - a33;
         num[0] = a13 - a31; num[1] = a12 + a21; num[2] = a23 + a32;
      end else begin
         ctl_in.sel = CASE_Z;
         rad = ONE + a33 - a11 - a22;
         num[0] = a21 - a12; num[1] = a13 + a31; num[2] = a23 + a32;
      end
      ctl_in.bad = (rad <= 0);
      for (int i = 0; i < 3; i++) begin
         ctl_in.neg[i] = num[i][EW-1];
         mag_in[i] = num[i][EW-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
      end
      // A radicand that is not positive is replaced by zero.
      v_in = ctl_in.bad ? '0 : (VW'(rad[RW-1:0]) << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff   <= v_in;
         mag_ff <= mag_in;
      end
   end

endmodule

### hw/rtl/rmq_sqrt_cell.sv
module rmq_sqrt_cell
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int K         = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  ctl_type                             ctl_i,
   input  logic [2*root_w(FRAC_BITS)-1:0]      v_i,
   input  logic [root_w(FRAC_BITS)+2:0]        rem_i,
   input  logic [root_w(FRAC_BITS)-1:0]        root_i,
   input  logic [2:0][MAG_W-1:0]               mag_i,
   output ctl_type                             ctl_ff,
   output logic [2*root_w(FRAC_BITS)-1:0]      v_ff,
   output logic [root_w(FRAC_BITS)+2:0]        rem_ff,
   output logic [root_w(FRAC_BITS)-1:0]        root_ff,
   output logic [2:0][MAG_W-1:0]               mag_ff
);
   localparam int TW = root_w(FRAC_BITS);
   localparam int RMW = TW + 3;

   logic [RMW-1:0] rem_sh, trial, rem_in;
   logic [TW-1:0] root_in;
   logic ge;

   // One result bit per cell: bring down two radicand bits and try root*4+1.
   always_comb begin
      rem_sh  = {rem_i[RMW-3:0], v_i[2*K+1 -: 2]};
      trial   = RMW'({root_i, 2'b01});
      ge      = (rem_sh >= trial);
      rem_in  = ge ? rem_sh - trial : rem_sh;
      root_in = {root_i[TW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff    <= v_i;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         mag_ff  <= mag_i;
      end
   end

endmodule

### hw/rtl/rmq_div_cell.sv
module rmq_div_cell
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int I         = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  ctl_type                             ctl_i,
   input  logic [root_w(FRAC_BITS)-1:0]        t_i,
   input  logic [2:0][div_w(FRAC_BITS)-1:0]    rem_i,
   input  logic [2:0][QUOT_W-1:0]              q_i,
   output ctl_type                             ctl_ff,
   output logic [root_w(FRAC_BITS)-1:0]        t_ff,
   output logic [2:0][div_w(FRAC_BITS)-1:0]    rem_ff,
   output logic [2:0][QUOT_W-1:0]              q_ff
);
   localparam int CW = div_w(FRAC_BITS);

   logic [CW-1:0] sub;
   logic [2:0][CW-1:0] rem_in;
   logic [2:0][QUOT_W-1:0] q_in;

   // Divisor is 2t; this cell settles quotient bit I in all three lanes.
   always_comb begin
      sub = CW'({t_i, 1'b0}) << I;
      for (int l = 0; l < 3; l++) begin
         q_in[l] = q_i[l];
         if (rem_i[l] >= sub) begin
            rem_in[l]  = rem_i[l] - sub;
            q_in[l][I] = 1'b1;
         end else begin
            rem_in[l] = rem_i[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff   <= t_i;
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

endmodule

### hw/rtl/rotation_matrix_to_quaternion.sv
// Converts a 3x3 rotation matrix, nine signed fixed point elements with
// FRAC_BITS fraction bits (Q2.14 by default), into the quaternion (w, x, y, z)
// by Shepperd's method. If the trace is positive, w carries the square root;
// otherwise the largest diagonal element picks x, y or z, with ties going to
// the later axis. The large component is the square root of the radicand,
// halved and rounded half up; the other three are element sums or
// differences divided by twice that root, rounded half away from zero. All
// four are saturated to 16 bits. A radicand that is not positive raises the
// invalid flag and forces all four components to zero. The block is a
// fully pipelined chain: one setup stage, one square root cell per root bit,
// sixteen long division cells (all three quotients in parallel) and an output
// register. It takes a new request every cycle while the chain is not stalled.
// Backpressure on the result side stalls the whole chain at once.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // m11, m12, m13, m21, m22, m23, m31, m32, m33 (16 bits each), lowest first
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // qw, qx, qy, qz (16 bits each), lowest first
   output logic [63:0]  rsp_tdata,
   // case_taken (2 bits), invalid (1 bit), lowest first
   output logic [2:0]   rsp_tuser
);
   localparam int TW = root_w(FRAC_BITS);
   localparam int VW = 2 * TW;
   localparam int CW = div_w(FRAC_BITS);
   localparam logic [QUOT_W-1:0] QMAX = QUOT_W'(32767);
   localparam logic [QUOT_W-1:0] QMIN = QUOT_W'(16'h8000);

   // The chain advances whenever the output register is free or draining.
   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic [8:0][ELEM_W-1:0] elem;
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         elem[i] = req_tdata[i*ELEM_W +: ELEM_W];
      end
   end

   // Square root section: stage 0 is the setup register.
   ctl_type               sq_ctl  [TW+1];
   logic [VW-1:0]         sq_v    [TW+1];
   logic [TW+2:0]         sq_rem  [TW+1];
   logic [TW-1:0]         sq_root [TW+1];
   logic [2:0][MAG_W-1:0] sq_mag  [TW+1];

   rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .elem     (elem),
      .ctl_ff   (sq_ctl[0]),
      .v_ff     (sq_v[0]),
      .mag_ff   (sq_mag[0])
   );
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar j = 0; j < TW; j++) begin : g_sqrt
      rmq_sqrt_cell #(.FRAC_BITS(FRAC_BITS), .K(TW-1-j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_i   (sq_ctl[j]),
         .v_i     (sq_v[j]),
         .rem_i   (sq_rem[j]),
         .root_i  (sq_root[j]),
         .mag_i   (sq_mag[j]),
         .ctl_ff  (sq_ctl[j+1]),
         .v_ff    (sq_v[j+1]),
         .rem_ff  (sq_rem[j+1]),
         .root_ff (sq_root[j+1]),
         .mag_ff  (sq_mag[j+1])
      );
   end

   // Division section: the dividend is |num| * ONE + t, so the floor gives
   // rounding half away from zero.
   ctl_type                dv_ctl [QUOT_W+1];
   logic [TW-1:0]          dv_t   [QUOT_W+1];
   logic [2:0][CW-1:0]     dv_rem [QUOT_W+1];
   logic [2:0][QUOT_W-1:0] dv_q   [QUOT_W+1];

   assign dv_ctl[0] = sq_ctl[TW];
   assign dv_t[0]   = sq_root[TW];
   assign dv_q[0]   = '0;
   for (genvar l = 0; l < 3; l++) begin : g_dividend
      assign dv_rem[0][l] = (CW'(sq_mag[TW][l]) << FRAC_BITS) + CW'(sq_root[TW]);
   end

   for (genvar j = 0; j < QUOT_W; j++) begin : g_div
      rmq_div_cell #(.FRAC_BITS(FRAC_BITS), .I(QUOT_W-1-j)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .ctl_i  (dv_ctl[j]),
         .t_i    (dv_t[j]),
         .rem_i  (dv_rem[j]),
         .q_i    (dv_q[j]),
         .ctl_ff (dv_ctl[j+1]),
         .t_ff   (dv_t[j+1]),
         .rem_ff (dv_rem[j+1]),
         .q_ff   (dv_q[j+1])
      );
   end

   // Result assembly: saturate, apply signs, place the large component.
   ctl_type                fin_ctl;
   logic [TW:0]            large_sum;
   logic [TW-1:0]          half_root;
   logic [QUOT_W-1:0]      large_q;
   logic [2:0][QUOT_W-1:0] other;
   logic [3:0][QUOT_W-1:0] quat;
   logic [63:0]            rsp_tdata_in;

   assign fin_ctl = dv_ctl[QUOT_W];

   always_comb begin
      large_sum = {1'b0, dv_t[QUOT_W]} + (TW+1)'(1);
      half_root = large_sum[TW:1];
      large_q   = (half_root > TW'(32767)) ? QMAX : QUOT_W'(half_root);
      for (int l = 0; l < 3; l++) begin
         if (dv_q[QUOT_W][l][QUOT_W-1]) begin
            other[l] = fin_ctl.neg[l] ? QMIN : QMAX;
         end else if (fin_ctl.neg[l]) begin
            other[l] = -dv_q[QUOT_W][l];
         end else begin
            other[l] = dv_q[QUOT_W][l];
         end
      end
      case (fin_ctl.sel)
         CASE_W:  quat = {other[2], other[1], other[0], large_q};
         CASE_X:  quat = {other[2], other[1], large_q, other[0]};
         CASE_Y:  quat = {other[2], large_q, other[1], other[0]};
         default: quat = {large_q, other[2], other[1], other[0]};
      endcase
      rsp_tdata_in = fin_ctl.bad ? '0 : quat;
   end

   logic        rsp_tvalid_ff;
   logic [63:0] rsp_tdata_ff;
   logic [2:0]  rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= fin_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= {fin_ctl.bad, fin_ctl.sel};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // An invalid result carries an all-zero quaternion.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == 64'd0)
      else $error("invalid result with nonzero quaternion");

   // With a positive trace and a valid radicand, w is strictly positive.
   a_w_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] && rsp_tuser[1:0] == CASE_W
      |-> !rsp_tdata[15] && rsp_tdata[15:0] != 16'd0)
      else $error("trace case gave nonpositive w");

   // A stalled result stays put while the chain is frozen.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && !$past(req_tready))
      else $error("chain moved during output stall");

endmodule

### tb/rotation_matrix_to_quaternion_test.sv
module rotation_matrix_to_quaternion_test;
   import rmq_pkg::*;

   // One pose conversion request and the quaternion it should produce.
   // Fields are listed from the highest bits down, so m11 sits lowest.
   typedef struct packed {
      logic signed [15:0] m33, m32, m31, m23, m22, m21, m13, m12, m11;
   } matrix_t;

   typedef struct packed {
      logic               invalid;
      case_type           sel;
      logic signed [15:0] qz, qy, qx, qw;
   } quat_t;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam longint ONE = 64'sd1 << FRAC;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;

   matrix_t pending_matrices[$];
   quat_t   expected_quats[$];
   int      mismatches = 0;
   int      cycle_count = 0;
   int      hold_off = 0;   // remaining cycles of a long receiver stall
   bit      stimulus_done = 0;

   rotation_matrix_to_quaternion u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Integer square root, bit by bit, on a nonnegative 64 bit value.
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root = 0;
      longint unsigned probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // num / (2*root) with rounding half away from zero.
   function automatic longint quotient(input longint num, input longint unsigned root);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? -num : num;
      q = ((mag << FRAC) + root) / (2 * root);
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Shepperd case choice, root and the three divided components.
   function automatic quat_t convert_matrix(input matrix_t m);
      longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
      longint tr, rad, n0, n1, n2;
      longint q[4];
      longint others[3];
      longint unsigned root;
      case_type sel;
      quat_t r;
      int j;
      a11 = m.m11; a12 = m.m12; a13 = m.m13;
      a21 = m.m21; a22 = m.m22; a23 = m.m23;
      a31 = m.m31; a32 = m.m32; a33 = m.m33;
      tr = a11 + a22 + a33;
      q = '{0, 0, 0, 0};
      if (tr > 0) begin
         sel = CASE_W; rad = ONE + tr;
         n0 = a32 - a23; n1 = a13 - a31; n2 = a21 - a12;
      end else if (a11 > a22 && a11 > a33) begin
         sel = CASE_X; rad = ONE + a11 - a22 - a33;
         n0 = a32 - a23; n1 = a12 + a21; n2 = a13 + a31;
      end else if (a22 > a33) begin
         sel = CASE_Y; rad = ONE + a22 - a11 - a33;
         n0 = a13 - a31; n1 = a12 + a21; n2 = a23 + a32;
      end else begin
         sel = CASE_Z; rad = ONE + a33 - a11 - a22;
         n0 = a21 - a12; n1 = a13 + a31; n2 = a23 + a32;
      end
      r.invalid = (rad <= 0);
      if (!r.invalid) begin
         root = int_sqrt(longint'(rad) << FRAC);
         others[0] = quotient(n0, root);
         others[1] = quotient(n1, root);
         others[2] = quotient(n2, root);
         j = 0;
         for (int k = 0; k < 4; k++) begin
            if (k == int'(sel)) begin
               q[k] = longint'((root + 1) >> 1);
            end else begin
               q[k] = others[j];
               j++;
            end
         end
      end
      r.sel = sel;
      r.qw = clamp16(q[0]); r.qx = clamp16(q[1]);
      r.qy = clamp16(q[2]); r.qz = clamp16(q[3]);
      return r;
   endfunction

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'h8000 + $urandom_range(0, 3);
         1: return 16'h7fff - $urandom_range(0, 3);
         2: return 16'(ONE) + $urandom_range(0, 8) - 4;
         3: return 16'($urandom_range(0, 400)) - 16'd200;
         default: return $urandom;
      endcase
   endfunction

   // A near rotation: a random signed permutation of the identity, with a
   // small disturbance, so each of the four cases is driven with real data.
   function automatic matrix_t rand_rotation();
      logic signed [15:0] e[9];
      int perm[3];
      int tmp, pick;
      matrix_t m;
      perm = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
         pick = $urandom_range(0, i);
         tmp = perm[i]; perm[i] = perm[pick]; perm[pick] = tmp;
      end
      for (int i = 0; i < 9; i++) e[i] = 16'($urandom_range(0, 8000)) - 16'sd4000;
      for (int i = 0; i < 3; i++) begin
         e[i * 3 + perm[i]] = ($urandom_range(0, 1) ? 16'(ONE) : -16'(ONE))
                              + 16'($urandom_range(0, 2000)) - 16'sd1000;
      end
      m = {e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};
      return m;
   endfunction

   function automatic matrix_t diag(input logic signed [15:0] d1, d2, d3);
      matrix_t m;
      m = '0;
      m.m11 = d1; m.m22 = d2; m.m33 = d3;
      m.m12 = 16'sd300; m.m13 = -16'sd500; m.m21 = -16'sd700;
      m.m23 = 16'sd900; m.m31 = 16'sd1100; m.m32 = -16'sd1300;
      return m;
   endfunction

   initial begin
      matrix_t m;
      // Identity and its signed variants: one request per case.
      pending_matrices.push_back(diag(16'sd16384, 16'sd16384, 16'sd16384));
      pending_matrices.push_back(diag(16'sd16384, -16'sd16384, -16'sd16384));
      pending_matrices.push_back(diag(-16'sd16384, 16'sd16384, -16'sd16384));
      pending_matrices.push_back(diag(-16'sd16384, -16'sd16384, 16'sd16384));
      // Ties on the diagonal with a nonpositive trace.
      pending_matrices.push_back(diag(-16'sd100, -16'sd100, -16'sd500));
      pending_matrices.push_back(diag(-16'sd100, -16'sd100, -16'sd100));
      pending_matrices.push_back(diag(16'sd0, 16'sd0, 16'sd0));
      pending_matrices.push_back(diag(-16'sd100, -16'sd500, -16'sd100));
      // Full negative diagonal, then traces of zero and one.
      pending_matrices.push_back(diag(-16'sd32768, -16'sd32768, -16'sd32768));
      pending_matrices.push_back(diag(-16'sd16384, 16'sd8192, 16'sd8192));
      pending_matrices.push_back(diag(-16'sd16383, 16'sd8192, 16'sd8192));
      pending_matrices.push_back(diag(16'sd1, 16'sd0, 16'sd0));
      // Full scale everywhere, both signs, to reach saturation.
      m = {9{16'sh7fff}};
      pending_matrices.push_back(m);
      m = {9{16'sh8000}};
      pending_matrices.push_back(m);
      m = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0001,
           16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0000};
      pending_matrices.push_back(m);
      m = '0;
      m.m11 = 16'sh8000; m.m22 = 16'sh8000; m.m33 = 16'sh0001;
      m.m12 = 16'sh7fff; m.m21 = 16'sh7fff; m.m32 = 16'sh8000;
      pending_matrices.push_back(m);
      for (int i = 0; i < 500; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            pending_matrices.push_back(rand_rotation());
         end else begin
            for (int k = 0; k < 9; k++) m[k * 16 +: 16] = rand_elem();
            pending_matrices.push_back(m);
         end
      end
      stimulus_done = 1;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: offers pending requests, idling now and then except during
   // a quiet window in the middle of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_matrices.size() != 0 &&
                ((cycle_count > 400 && cycle_count < 900) || $urandom_range(0, 99) >= 33)) begin
               req_tdata  <= pending_matrices[0];
               req_tvalid <= 1'b1;
               expected_quats.push_back(convert_matrix(pending_matrices[0]));
               void'(pending_matrices.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness: random stalls, a quiet window, and one long
   // hold-off so the pipeline fills and pushes back on the request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (cycle_count == 200) begin
         hold_off <= 120;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (cycle_count > 400 && cycle_count < 900) || $urandom_range(0, 99) >= 33;
      end
   end

   // Monitor: compares every result with the oldest expected quaternion.
   always @(posedge clock) begin
      quat_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         if (expected_quats.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result %h", got);
         end else begin
            want = expected_quats.pop_front();
            if (got !== want) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d case=%0d inv=%0b",
                           want.qw, want.qx, want.qy, want.qz, want.sel, want.invalid);
                  $display("          actual   w=%0d x=%0d y=%0d z=%0d case=%0d inv=%0b",
                           got.qw, got.qx, got.qy, got.qz, got.sel, got.invalid);
               end
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (pending_matrices.size() == 0 && !req_tvalid && expected_quats.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_quats.size() == 0) begin
         $display("rotation_matrix_to_quaternion verification clean");
      end else begin
         $display("rotation_matrix_to_quaternion verification failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
   end

endmodule

### rotation_matrix_to_quaternion.f
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_sqrt_cell.sv
hw/rtl/rmq_div_cell.sv
hw/rtl/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_test.sv
